// ===== hw/rtl/mopc_pkg.sv =====
`default_nettype none
package mopc_pkg;

   localparam int unsigned ChanWidth  = 8;
   localparam int unsigned PixWidth   = 32;
   localparam int unsigned ProdWidth  = 2 * ChanWidth;
   localparam int unsigned ColorChans = 3;

   localparam logic [ChanWidth-1:0] FullScale = 8'hFF;
   localparam logic [ProdWidth:0]   RoundBias = 17'd128;

   // Input beat layout: source pixel, then mask, then destination pixel.
   localparam int unsigned ReqDataWidth = 72;
   localparam int unsigned SrcLsb       = 0;
   localparam int unsigned MaskLsb      = 32;
   localparam int unsigned DestLsb      = 40;

   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 32;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_USE_CONSTANT_SOURCE  = 2'd0,
      CSR_CONSTANT_SOURCE_ARGB = 2'd1,
      CSR_MASK_ENABLED         = 2'd2,
      CSR_UNUSED               = 2'd3
   } csr_index_type;

   // One pixel entering the blend pipeline, source already in ABGR order.
   typedef struct packed {
      logic [PixWidth-1:0]              src_abgr;
      logic [ChanWidth-1:0]             mask;
      logic [ColorChans*ChanWidth-1:0]  dest_bgr;
   } pix_in_type;

   // Rounded division by 255 of an 8x8 product: t = p + 128, (t + (t >> 8)) >> 8.
   function automatic logic [ChanWidth-1:0] div255(input logic [ProdWidth-1:0] prod);
      logic [ProdWidth:0]   t;
      logic [ProdWidth:0]   s;
      logic [ChanWidth:0]   q;
      t = {1'b0, prod} + RoundBias;
      s = t + {{ChanWidth{1'b0}}, t[ProdWidth:ChanWidth]};
      q = s[ProdWidth:ChanWidth];
      div255 = q[ChanWidth] ? FullScale : q[ChanWidth-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/mopc_pipe.sv =====
`default_nettype none
module mopc_pipe (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          in_valid,
   output logic                         in_ready,
   input  mopc_pkg::pix_in_type         in_pix,
   output logic                         out_valid,
   input  wire                          out_ready,
   output logic [mopc_pkg::PixWidth-1:0] out_pixel
);
   import mopc_pkg::*;

   localparam int unsigned SrcChans = 4;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;

   // Stage 1: masked source products.
   logic [ProdWidth-1:0]            sprod_ff [SrcChans];
   logic [ColorChans*ChanWidth-1:0] dest1_ff;
   // Stage 2: masked source channels and the inverse alpha.
   logic [ChanWidth-1:0]            msrc2_ff [ColorChans];
   logic [ChanWidth-1:0]            inv2_ff;
   logic [ColorChans*ChanWidth-1:0] dest2_ff;
   // Stage 3: scaled destination products.
   logic [ProdWidth-1:0]            dprod_ff [ColorChans];
   logic [ChanWidth-1:0]            msrc3_ff [ColorChans];
   // Stage 4: output register.
   logic [PixWidth-1:0]             result_ff;

   logic [PixWidth-1:0]             result_in;

   // Each stage moves when its successor is empty or moving.
   assign en4      = !v4_ff || out_ready;
   assign en3      = !v3_ff || en4;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         for (int c = 0; c < SrcChans; c++) begin
            sprod_ff[c] <= {{ChanWidth{1'b0}}, in_pix.src_abgr[c*ChanWidth +: ChanWidth]}
                           * {{ChanWidth{1'b0}}, in_pix.mask};
         end
         dest1_ff <= in_pix.dest_bgr;
      end
      if (en2) begin
         for (int c = 0; c < ColorChans; c++) begin
            msrc2_ff[c] <= div255(sprod_ff[c]);
         end
         inv2_ff  <= FullScale - div255(sprod_ff[SrcChans-1]);
         dest2_ff <= dest1_ff;
      end
      if (en3) begin
         for (int c = 0; c < ColorChans; c++) begin
            dprod_ff[c] <= {{ChanWidth{1'b0}}, dest2_ff[c*ChanWidth +: ChanWidth]}
                           * {{ChanWidth{1'b0}}, inv2_ff};
            msrc3_ff[c] <= msrc2_ff[c];
         end
      end
      if (en4) begin
         result_ff <= result_in;
      end
   end

   always_comb begin
      logic [ChanWidth:0] sum;
      result_in = '0;
      result_in[PixWidth-1 -: ChanWidth] = FullScale;
      for (int c = 0; c < ColorChans; c++) begin
         sum = {1'b0, msrc3_ff[c]} + {1'b0, div255(dprod_ff[c])};
         result_in[c*ChanWidth +: ChanWidth] = sum[ChanWidth] ? FullScale
                                                              : sum[ChanWidth-1:0];
      end
   end

   assign out_valid = v4_ff;
   assign out_pixel = result_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/masked_over_pixel_composite.sv =====
`default_nettype none
// Masked OVER compositor for premultiplied 8-bit pixels.
// Input channel (req_): one beat carries a premultiplied ARGB source pixel,
// an 8-bit coverage mask and an xBGR destination pixel. Result channel
// (rsp_): one beat per input beat, the composited xBGR pixel with the top
// byte forced to 255, in input order.
// Configuration (csr_): index 0 selects the constant source register,
// index 1 holds that constant ARGB pixel, index 2 enables the per-pixel
// mask (when clear the mask is 255). Write only while the block is idle.
// Throughput is one pixel per cycle unless the result channel stalls.
// Each beat passes four register stages: source times mask, rounded
// divide and inverse alpha, destination times inverse alpha, and
// rounded divide with saturating add into the output register.
// A stalled receiver holds the result; earlier stages keep filling until
// every stage is full, and only then does req_tready drop.
// Synchronous reset empties the pipeline and restores the registers:
// constant source off, constant pixel zero, mask enabled.
module masked_over_pixel_composite (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     req_tvalid,
   output logic                                    req_tready,
   // Fields from bit 0: source_pixel[31:0], mask_value[39:32], dest_pixel[71:40].
   input  wire  [mopc_pkg::ReqDataWidth-1:0]       req_tdata,
   output logic                                    rsp_tvalid,
   input  wire                                     rsp_tready,
   // Fields from bit 0: result_pixel[31:0].
   output logic [mopc_pkg::PixWidth-1:0]           rsp_tdata,
   input  wire                                     csr_write,
   input  wire  [mopc_pkg::CsrIndexWidth-1:0]      csr_index,
   input  wire  [mopc_pkg::CsrDataWidth-1:0]       csr_wdata
);
   import mopc_pkg::*;

   logic                use_const_ff;
   logic [PixWidth-1:0] const_argb_ff;
   logic                mask_en_ff;

   logic [PixWidth-1:0]  src_argb;
   logic [ChanWidth-1:0] mask;
   pix_in_type           pix;

   always_ff @(posedge clock) begin
      if (reset) begin
         use_const_ff  <= 1'b0;
         const_argb_ff <= '0;
         mask_en_ff    <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_USE_CONSTANT_SOURCE:  use_const_ff  <= csr_wdata[0];
            CSR_CONSTANT_SOURCE_ARGB: const_argb_ff <= csr_wdata[PixWidth-1:0];
            CSR_MASK_ENABLED:         mask_en_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      src_argb = use_const_ff ? const_argb_ff : req_tdata[SrcLsb +: PixWidth];
      mask     = mask_en_ff ? req_tdata[MaskLsb +: ChanWidth] : FullScale;
      // ARGB to ABGR: swap the red and blue bytes.
      pix.src_abgr = {src_argb[31:24], src_argb[7:0], src_argb[15:8], src_argb[23:16]};
      pix.mask     = mask;
      pix.dest_bgr = req_tdata[DestLsb +: ColorChans*ChanWidth];
   end

   mopc_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_pix    (pix),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_pixel (rsp_tdata)
   );

endmodule
`default_nettype wire
